[sv/psu_pkg.sv]
// Package: shared types, register indexes and constants of the particle update core.
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;

	localparam int FRAME_BITS = 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_RATE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIFE_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 3'd7;

	localparam logic [1:0] ANIM_NONE = 2'd0;
	localparam logic [1:0] ANIM_ONCE = 2'd1;
	localparam logic [1:0] ANIM_LOOP = 2'd2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [15:0] LIFE_CAP = 16'd40960;
	localparam logic [16:0] TIMER_MAX = 17'h1FFFF;
	localparam logic signed [23:0] SCALE_ONE = 24'sh010000;
	localparam logic signed [29:0] SCALE_MAX = 30'sd8388607;
	localparam logic signed [29:0] SCALE_MIN = -30'sd8388608;

	typedef struct packed {
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
		logic signed [31:0] spin_rate;
		logic signed [23:0] growth_rate;
		logic [15:0] life_limit;
		logic [15:0] frame_period;
		logic [7:0] frame_total;
		logic [1:0] anim_mode;
	} cfg_t;

	typedef struct packed {
		logic command;
		logic [15:0] delta_time;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [23:0] start_scale;
	} in_beat_t;

	typedef struct packed {
		logic alive;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [23:0] out_scale;
		logic signed [31:0] out_angle;
		logic [7:0] out_frame;
	} out_beat_t;

	typedef struct packed {
		logic command;
		logic [15:0] delta_time;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [23:0] start_scale;
		logic signed [31:0] step_x;
		logic signed [31:0] step_y;
		logic signed [31:0] step_angle;
		logic signed [28:0] step_scale;
	} prod_t;

endpackage
`default_nettype wire

[sv/psu_cfg_regs.sv]
// Configuration register file of the particle update core.
`timescale 1ns / 1ps
`default_nettype none
module psu_cfg_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
	output psu_pkg::cfg_t cfg
);

	psu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.velocity_x <= '0;
			cfg_q.velocity_y <= '0;
			cfg_q.spin_rate <= '0;
			cfg_q.growth_rate <= '0;
			cfg_q.life_limit <= psu_pkg::LIFE_CAP;
			cfg_q.frame_period <= '0;
			cfg_q.frame_total <= '0;
			cfg_q.anim_mode <= psu_pkg::ANIM_NONE;
		end else if (cfg_we) begin
			case (cfg_idx)
				psu_pkg::REG_VELOCITY_X: cfg_q.velocity_x <= $signed(cfg_data);
				psu_pkg::REG_VELOCITY_Y: cfg_q.velocity_y <= $signed(cfg_data);
				psu_pkg::REG_SPIN_RATE: cfg_q.spin_rate <= $signed(cfg_data);
				psu_pkg::REG_GROWTH_RATE: cfg_q.growth_rate <= $signed(cfg_data[23:0]);
				psu_pkg::REG_LIFE_LIMIT: begin
					// drop lifetimes above the cap
					if (cfg_data[15:0] <= psu_pkg::LIFE_CAP) begin
						cfg_q.life_limit <= cfg_data[15:0];
					end
				end
				psu_pkg::REG_FRAME_PER: cfg_q.frame_period <= cfg_data[15:0];
				psu_pkg::REG_FRAME_TOTAL: cfg_q.frame_total <= cfg_data[7:0];
				psu_pkg::REG_ANIM_MODE: cfg_q.anim_mode <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[sv/psu_rate_mult.sv]
// Input register and rate-times-dt products of the particle update core.
`timescale 1ns / 1ps
`default_nettype none
module psu_rate_mult (
	input  wire logic clk,
	input  wire logic arst_n,
	input  psu_pkg::cfg_t cfg,
	input  wire logic in_valid,
	output logic in_stall,
	input  psu_pkg::in_beat_t in_data,
	output logic prod_valid,
	input  wire logic prod_stall,
	output psu_pkg::prod_t prod_data
);

	logic valid_s1;
	psu_pkg::in_beat_t data_s1;
	logic ready_s1;
	logic signed [16:0] dt_ext;
	logic signed [48:0] prod_x;
	logic signed [48:0] prod_y;
	logic signed [48:0] prod_a;
	logic signed [40:0] prod_g;
	psu_pkg::prod_t prod_next;

	assign ready_s1 = !valid_s1 || !prod_stall;
	assign in_stall = !ready_s1;

	always_comb begin
		dt_ext = $signed({1'b0, data_s1.delta_time});
		prod_x = $signed(cfg.velocity_x) * dt_ext;
		prod_y = $signed(cfg.velocity_y) * dt_ext;
		prod_a = $signed(cfg.spin_rate) * dt_ext;
		prod_g = $signed(cfg.growth_rate) * dt_ext;
		prod_next.command = data_s1.command;
		prod_next.delta_time = data_s1.delta_time;
		prod_next.start_x = data_s1.start_x;
		prod_next.start_y = data_s1.start_y;
		prod_next.start_scale = data_s1.start_scale;
		// floor of product / 4096, kept to the wrap width
		prod_next.step_x = prod_x[43:12];
		prod_next.step_y = prod_y[43:12];
		prod_next.step_angle = prod_a[43:12];
		prod_next.step_scale = prod_g[40:12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign prod_valid = valid_s1;
	assign prod_data = prod_next;

endmodule
`default_nettype wire

[sv/psu_state_update.sv]
// Particle state registers, per-beat update logic and result register.
`timescale 1ns / 1ps
`default_nettype none
module psu_state_update (
	input  wire logic clk,
	input  wire logic arst_n,
	input  psu_pkg::cfg_t cfg,
	input  wire logic prod_valid,
	output logic prod_stall,
	input  psu_pkg::prod_t prod_data,
	output logic out_valid,
	input  wire logic out_stall,
	output psu_pkg::out_beat_t out_data
);

	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [23:0] size_q;
	logic signed [31:0] angle_q;
	logic [16:0] age_q;
	logic [16:0] ftimer_q;
	logic [psu_pkg::FRAME_BITS-1:0] findex_q;
	logic alive_q;
	logic out_valid_q;
	psu_pkg::out_beat_t out_q;

	logic signed [31:0] pos_x_n;
	logic signed [31:0] pos_y_n;
	logic signed [23:0] size_n;
	logic signed [31:0] angle_n;
	logic [16:0] age_n;
	logic [16:0] ftimer_n;
	logic [psu_pkg::FRAME_BITS-1:0] findex_n;
	logic [psu_pkg::FRAME_BITS-1:0] findex_inc;
	logic alive_n;
	logic signed [29:0] size_sum;
	logic [17:0] age_sum;
	logic [17:0] ft_sum;
	logic [16:0] ft_sat;
	logic upd;
	psu_pkg::out_beat_t out_n;

	assign prod_stall = out_valid_q && out_stall;
	assign upd = prod_valid && !prod_stall;

	always_comb begin
		pos_x_n = pos_x_q;
		pos_y_n = pos_y_q;
		size_n = size_q;
		angle_n = angle_q;
		age_n = age_q;
		ftimer_n = ftimer_q;
		findex_n = findex_q;
		alive_n = alive_q;
		findex_inc = findex_q + 1'b1;
		size_sum = 30'(size_q) + 30'(prod_data.step_scale);
		age_sum = {1'b0, age_q} + 18'(prod_data.delta_time);
		ft_sum = {1'b0, ftimer_q} + 18'(prod_data.delta_time);
		ft_sat = ft_sum[17] ? psu_pkg::TIMER_MAX : ft_sum[16:0];
		if (prod_data.command == psu_pkg::CMD_START) begin
			pos_x_n = prod_data.start_x;
			pos_y_n = prod_data.start_y;
			size_n = prod_data.start_scale;
			angle_n = '0;
			age_n = '0;
			ftimer_n = '0;
			findex_n = '0;
			alive_n = 1'b1;
		end else if (alive_q) begin
			pos_x_n = pos_x_q + prod_data.step_x;
			pos_y_n = pos_y_q + prod_data.step_y;
			angle_n = angle_q + prod_data.step_angle;
			if (size_sum > psu_pkg::SCALE_MAX) begin
				size_n = 24'(psu_pkg::SCALE_MAX);
			end else if (size_sum < psu_pkg::SCALE_MIN) begin
				size_n = 24'(psu_pkg::SCALE_MIN);
			end else begin
				size_n = size_sum[23:0];
			end
			if (size_sum <= 30'sd0) begin
				alive_n = 1'b0;
			end
			age_n = age_sum[17] ? psu_pkg::TIMER_MAX : age_sum[16:0];
			if (age_n >= {1'b0, cfg.life_limit}) begin
				alive_n = 1'b0;
			end
			if (cfg.anim_mode == psu_pkg::ANIM_ONCE || cfg.anim_mode == psu_pkg::ANIM_LOOP) begin
				ftimer_n = ft_sat;
				if (ft_sat >= {1'b0, cfg.frame_period}) begin
					// advance frame, clear timer
					ftimer_n = '0;
					findex_n = findex_inc;
					if (16'(findex_inc) >= 16'(cfg.frame_total)) begin
						if (cfg.anim_mode == psu_pkg::ANIM_LOOP) begin
							findex_n = '0;
						end else begin
							alive_n = 1'b0;
						end
					end
				end
			end
		end
		out_n.alive = alive_n;
		out_n.out_x = pos_x_n;
		out_n.out_y = pos_y_n;
		out_n.out_scale = size_n;
		out_n.out_angle = angle_n;
		out_n.out_frame = 8'(findex_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			size_q <= psu_pkg::SCALE_ONE;
			angle_q <= '0;
			age_q <= '0;
			ftimer_q <= '0;
			findex_q <= '0;
			alive_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				pos_x_q <= pos_x_n;
				pos_y_q <= pos_y_n;
				size_q <= size_n;
				angle_q <= angle_n;
				age_q <= age_n;
				ftimer_q <= ftimer_n;
				findex_q <= findex_n;
				alive_q <= alive_n;
			end
			if (!prod_stall) begin
				out_valid_q <= prod_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			out_q <= out_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

[sv/particle_state_update_core.sv]
// Top level of the particle update core: config registers, product stage, state update.
// A result beat passes the input register, then the result register; out_stall can hold it.
// Throughput: one beat per cycle while out_stall is low; products, sums and compares
// all fit between input and result registers; one more beat is taken while a result waits.
// Reset (arst_n low): config to defaults (lifetime 10 s), particle dead at
// origin with scale 1.0, all pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none
module particle_state_update_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  psu_pkg::in_beat_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output psu_pkg::out_beat_t out_data
);

	psu_pkg::cfg_t cfg;
	logic prod_valid;
	logic prod_stall;
	psu_pkg::prod_t prod_data;

	psu_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	psu_rate_mult u_mult (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.prod_valid(prod_valid),
		.prod_stall(prod_stall),
		.prod_data(prod_data)
	);

	psu_state_update u_upd (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.prod_valid(prod_valid),
		.prod_stall(prod_stall),
		.prod_data(prod_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule
`default_nettype wire
